// ===== rtl/rbst_pkg.sv =====
`timescale 1ns / 1ps

package rbst_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   localparam int DIV_BITS  = COORD_WIDTH + FRAC_BITS;
   localparam int REM_W     = COORD_WIDTH + 1;
   localparam int DIV_LAT   = DIV_BITS + 1;
   localparam int TOTAL_LAT = 1 + DIV_LAT + 2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   localparam coord_type COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam coord_type COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

   typedef struct packed {
      logic      ok;
      coord_type t_near;
      coord_type t_far;
   } axis_type;

endpackage

// ===== rtl/rbst_div.sv =====
`timescale 1ns / 1ps

module rbst_div import rbst_pkg::*; (
   input  logic                   clock,
   input  logic [COORD_WIDTH-1:0] num_mag,
   input  logic [COORD_WIDTH-1:0] den_mag,
   input  logic                   neg,
   output coord_type              quot
);

   logic [REM_W-1:0]       rem_ff [DIV_BITS];
   logic [DIV_BITS-1:0]    quo_ff [DIV_BITS];
   logic [COORD_WIDTH-1:0] num_ff [DIV_BITS];
   logic [COORD_WIDTH-1:0] den_ff [DIV_BITS];
   logic                   neg_ff [DIV_BITS];

   generate
      for (genvar i = 0; i < DIV_BITS; i++) begin : g_stage
         logic [REM_W-1:0]       rem_prev;
         logic [DIV_BITS-1:0]    quo_prev;
         logic [COORD_WIDTH-1:0] num_prev;
         logic [COORD_WIDTH-1:0] den_prev;
         logic                   neg_prev;
         logic                   bit_in;
         logic [REM_W-1:0]       trial;
         logic                   take;

         if (i == 0) begin : g_first
            assign rem_prev = '0;
            assign quo_prev = '0;
            assign num_prev = num_mag;
            assign den_prev = den_mag;
            assign neg_prev = neg;
         end else begin : g_next
            assign rem_prev = rem_ff[i-1];
            assign quo_prev = quo_ff[i-1];
            assign num_prev = num_ff[i-1];
            assign den_prev = den_ff[i-1];
            assign neg_prev = neg_ff[i-1];
         end

         if (DIV_BITS - 1 - i >= FRAC_BITS) begin : g_num_bit
            assign bit_in = num_prev[DIV_BITS-1-i-FRAC_BITS];
         end else begin : g_zero_bit
            assign bit_in = 1'b0;
         end

         assign trial = {rem_prev[REM_W-2:0], bit_in};
         assign take  = (trial >= {1'b0, den_prev});

         always_ff @(posedge clock) begin
            rem_ff[i] <= take ? (trial - {1'b0, den_prev}) : trial;
            quo_ff[i] <= {quo_prev[DIV_BITS-2:0], take};
            num_ff[i] <= num_prev;
            den_ff[i] <= den_prev;
            neg_ff[i] <= neg_prev;
         end
      end
   endgenerate

   logic [DIV_BITS-1:0]    quo_last;
   logic                   neg_last;
   logic [DIV_BITS-1:0]    cap;
   logic [DIV_BITS-1:0]    clipped;
   logic [COORD_WIDTH-1:0] mag;
   coord_type              quot_in;
   coord_type              quot_ff;

   assign quo_last = quo_ff[DIV_BITS-1];
   assign neg_last = neg_ff[DIV_BITS-1];
   assign cap      = {{(DIV_BITS-COORD_WIDTH){1'b0}}, neg_last, {(COORD_WIDTH-1){~neg_last}}};
   assign clipped  = (quo_last > cap) ? cap : quo_last;
   assign mag      = clipped[COORD_WIDTH-1:0];
   assign quot_in  = neg_last ? coord_type'(-mag) : coord_type'(mag);

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

// ===== rtl/rbst_lane.sv =====
`timescale 1ns / 1ps

module rbst_lane import rbst_pkg::*; (
   input  logic      clock,
   input  coord_type box_min,
   input  coord_type box_max,
   input  coord_type origin,
   input  coord_type direction,
   output axis_type  result
);

   logic                   dir_neg;
   logic                   dir_zero;
   logic                   in_slab;
   coord_type              near_corner;
   coord_type              far_corner;
   logic signed [COORD_WIDTH:0] near_diff;
   logic signed [COORD_WIDTH:0] far_diff;
   logic [COORD_WIDTH:0]   near_abs;
   logic [COORD_WIDTH:0]   far_abs;
   logic [COORD_WIDTH-1:0] dir_mag;

   assign dir_neg     = direction[COORD_WIDTH-1];
   assign dir_zero    = (direction == '0);
   assign in_slab     = (box_min <= origin) && (origin <= box_max);
   assign near_corner = dir_neg ? box_max : box_min;
   assign far_corner  = dir_neg ? box_min : box_max;
   assign near_diff   = {near_corner[COORD_WIDTH-1], near_corner} -
                        {origin[COORD_WIDTH-1], origin};
   assign far_diff    = {far_corner[COORD_WIDTH-1], far_corner} -
                        {origin[COORD_WIDTH-1], origin};
   assign near_abs    = near_diff[COORD_WIDTH] ? -near_diff : near_diff;
   assign far_abs     = far_diff[COORD_WIDTH] ? -far_diff : far_diff;
   assign dir_mag     = dir_neg ? -direction : direction;

   logic [COORD_WIDTH-1:0] near_mag_ff;
   logic [COORD_WIDTH-1:0] far_mag_ff;
   logic [COORD_WIDTH-1:0] dir_mag_ff;
   logic                   near_neg_ff;
   logic                   far_neg_ff;
   logic                   zero_ff    [DIV_LAT+1];
   logic                   in_slab_ff [DIV_LAT+1];

   always_ff @(posedge clock) begin
      near_mag_ff   <= near_abs[COORD_WIDTH-1:0];
      far_mag_ff    <= far_abs[COORD_WIDTH-1:0];
      dir_mag_ff    <= dir_mag;
      near_neg_ff   <= near_diff[COORD_WIDTH] ^ dir_neg;
      far_neg_ff    <= far_diff[COORD_WIDTH] ^ dir_neg;
      zero_ff[0]    <= dir_zero;
      in_slab_ff[0] <= in_slab;
      for (int i = 1; i <= DIV_LAT; i++) begin
         zero_ff[i]    <= zero_ff[i-1];
         in_slab_ff[i] <= in_slab_ff[i-1];
      end
   end

   coord_type near_q;
   coord_type far_q;

   rbst_div u_div_near (
      .clock   (clock),
      .num_mag (near_mag_ff),
      .den_mag (dir_mag_ff),
      .neg     (near_neg_ff),
      .quot    (near_q)
   );

   rbst_div u_div_far (
      .clock   (clock),
      .num_mag (far_mag_ff),
      .den_mag (dir_mag_ff),
      .neg     (far_neg_ff),
      .quot    (far_q)
   );

   always_comb begin
      if (zero_ff[DIV_LAT]) begin
         result.ok     = in_slab_ff[DIV_LAT];
         result.t_near = COORD_MIN;
         result.t_far  = COORD_MAX;
      end else begin
         result.ok     = 1'b1;
         result.t_near = near_q;
         result.t_far  = far_q;
      end
   end

endmodule

// ===== rtl/rbst_merge.sv =====
`timescale 1ns / 1ps

module rbst_merge import rbst_pkg::*; (
   input  logic      clock,
   input  axis_type  axis_x,
   input  axis_type  axis_y,
   input  axis_type  axis_z,
   output logic      hit,
   output coord_type t_near,
   output coord_type t_far
);

   axis_type xy_in;
   axis_type xy_ff;
   axis_type z_ff;
   axis_type all_in;
   axis_type all_ff;

   always_comb begin
      xy_in.ok     = axis_x.ok && axis_y.ok &&
                     !(axis_x.t_near > axis_y.t_far) && !(axis_y.t_near > axis_x.t_far);
      xy_in.t_near = (axis_y.t_near > axis_x.t_near) ? axis_y.t_near : axis_x.t_near;
      xy_in.t_far  = (axis_y.t_far < axis_x.t_far) ? axis_y.t_far : axis_x.t_far;
   end

   always_ff @(posedge clock) begin
      xy_ff <= xy_in;
      z_ff  <= axis_z;
   end

   always_comb begin
      all_in.ok = xy_ff.ok && z_ff.ok &&
                  !(xy_ff.t_near > z_ff.t_far) && !(z_ff.t_near > xy_ff.t_far);
      if (all_in.ok) begin
         all_in.t_near = (z_ff.t_near > xy_ff.t_near) ? z_ff.t_near : xy_ff.t_near;
         all_in.t_far  = (z_ff.t_far < xy_ff.t_far) ? z_ff.t_far : xy_ff.t_far;
      end else begin
         all_in.t_near = '0;
         all_in.t_far  = '0;
      end
   end

   always_ff @(posedge clock) begin
      all_ff <= all_in;
   end

   assign hit    = all_ff.ok;
   assign t_near = all_ff.t_near;
   assign t_far  = all_ff.t_far;

endmodule

// ===== rtl/ray_box_slab_test.sv =====
`timescale 1ns / 1ps

// Ray versus box slab test in signed Q16.16. The block takes one beat per
// cycle and is never busy; each beat gives one result on rsp_*, marked by
// rsp_valid for one cycle. The pipeline is made of the six pipelined
// restoring dividers, one per slab plane, that produce one quotient bit
// per stage over 48 stages, plus an input stage, a saturation stage and
// two merge stages. The receiver cannot stall the block, so it must take
// every result as it appears.

module ray_box_slab_test import rbst_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  coord_type req_box_min_x,
   input  coord_type req_box_min_y,
   input  coord_type req_box_min_z,
   input  coord_type req_box_max_x,
   input  coord_type req_box_max_y,
   input  coord_type req_box_max_z,
   input  coord_type req_origin_x,
   input  coord_type req_origin_y,
   input  coord_type req_origin_z,
   input  coord_type req_direction_x,
   input  coord_type req_direction_y,
   input  coord_type req_direction_z,
   output logic      rsp_valid,
   output logic      rsp_hit,
   output coord_type rsp_t_near,
   output coord_type rsp_t_far
);

   logic [TOTAL_LAT-1:0] valid_ff;
   logic [TOTAL_LAT-1:0] valid_in;

   assign busy     = 1'b0;
   assign valid_in = {valid_ff[TOTAL_LAT-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[TOTAL_LAT-1];

   axis_type axis_x;
   axis_type axis_y;
   axis_type axis_z;

   rbst_lane u_lane_x (
      .clock     (clock),
      .box_min   (req_box_min_x),
      .box_max   (req_box_max_x),
      .origin    (req_origin_x),
      .direction (req_direction_x),
      .result    (axis_x)
   );

   rbst_lane u_lane_y (
      .clock     (clock),
      .box_min   (req_box_min_y),
      .box_max   (req_box_max_y),
      .origin    (req_origin_y),
      .direction (req_direction_y),
      .result    (axis_y)
   );

   rbst_lane u_lane_z (
      .clock     (clock),
      .box_min   (req_box_min_z),
      .box_max   (req_box_max_z),
      .origin    (req_origin_z),
      .direction (req_direction_z),
      .result    (axis_z)
   );

   rbst_merge u_merge (
      .clock  (clock),
      .axis_x (axis_x),
      .axis_y (axis_y),
      .axis_z (axis_z),
      .hit    (rsp_hit),
      .t_near (rsp_t_near),
      .t_far  (rsp_t_far)
   );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import rbst_pkg::*;

   typedef logic [11:0][COORD_WIDTH-1:0] ray_box_type;

   typedef struct packed {
      logic      hit;
      coord_type t_near;
      coord_type t_far;
   } slab_result_type;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PAUSE_AT    = 150;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   coord_type req_f [12];
   logic      rsp_valid;
   logic      rsp_hit;
   coord_type rsp_t_near;
   coord_type rsp_t_far;

   ray_box_type     pending_boxes[$];
   slab_result_type expected_hits[$];
   int              errors = 0;
   int              sent = 0;
   int              cycles = 0;
   bit              beat_taken = 1'b0;
   int              gap_left = 0;
   int              burst_left = 0;

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < 12; i++) req_f[i] = '0;
   end

   ray_box_slab_test i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_box_min_x(req_f[0]), .req_box_min_y(req_f[1]), .req_box_min_z(req_f[2]),
      .req_box_max_x(req_f[3]), .req_box_max_y(req_f[4]), .req_box_max_z(req_f[5]),
      .req_origin_x(req_f[6]), .req_origin_y(req_f[7]), .req_origin_z(req_f[8]),
      .req_direction_x(req_f[9]), .req_direction_y(req_f[10]),
      .req_direction_z(req_f[11]),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_t_near(rsp_t_near),
      .rsp_t_far(rsp_t_far)
   );

   function automatic void add_box(ray_box_type b);
      pending_boxes.insert(pending_boxes.size(), b);
   endfunction

   function automatic coord_type plane_distance(coord_type corner, coord_type org,
                                                coord_type dir);
      longint num;
      longint quo;
      num = (longint'(corner) - longint'(org)) <<< FRAC_BITS;
      quo = num / longint'(dir);
      if (quo > longint'(COORD_MAX)) return COORD_MAX;
      if (quo < longint'(COORD_MIN)) return COORD_MIN;
      return coord_type'(quo);
   endfunction

   function automatic slab_result_type predict_slab_hit(ray_box_type b);
      slab_result_type r;
      coord_type       n, f, an, af, lo, hi, o, d;
      bit              ok;
      n = '0;
      f = '0;
      ok = 1'b1;
      for (int a = 0; a < 3; a++) begin
         lo = b[a];
         hi = b[3+a];
         o  = b[6+a];
         d  = b[9+a];
         if (!ok) continue;
         if (d == 0) begin
            if (lo <= o && o <= hi) begin
               an = COORD_MIN;
               af = COORD_MAX;
            end else begin
               ok = 1'b0;
               continue;
            end
         end else if (d > 0) begin
            an = plane_distance(lo, o, d);
            af = plane_distance(hi, o, d);
         end else begin
            an = plane_distance(hi, o, d);
            af = plane_distance(lo, o, d);
         end
         if (a == 0) begin
            n = an;
            f = af;
         end else if (n > af || an > f) begin
            ok = 1'b0;
         end else begin
            if (an > n) n = an;
            if (af < f) f = af;
         end
      end
      r.hit    = ok;
      r.t_near = ok ? n : '0;
      r.t_far  = ok ? f : '0;
      return r;
   endfunction

   function automatic coord_type rand_coord(int span);
      return coord_type'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic ray_box_type random_ray_box();
      ray_box_type b;
      coord_type   p, q;
      int          mode;
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
         for (int i = 0; i < 12; i++) b[i] = $urandom;
         if ($urandom_range(0, 3) == 0) b[9 + $urandom_range(0, 2)] = '0;
      end else begin
         for (int a = 0; a < 3; a++) begin
            p = rand_coord(1 << 22);
            q = rand_coord(1 << 22);
            b[a]   = (p < q) ? p : q;
            b[3+a] = (p < q) ? q : p;
            b[6+a] = rand_coord(1 << 23);
            case ($urandom_range(0, 7))
               0: b[9+a] = '0;
               1: b[9+a] = rand_coord(4);
               2: b[9+a] = $urandom;
               default: b[9+a] = rand_coord(1 << 18);
            endcase
         end
         if (mode == 2) b[$urandom_range(0, 2)] = b[3 + $urandom_range(0, 2)] + 1;
      end
      return b;
   endfunction

   function automatic ray_box_type make_box(coord_type lo, coord_type hi, coord_type o,
                                            coord_type d);
      ray_box_type b;
      for (int a = 0; a < 3; a++) begin
         b[a] = lo;
         b[3+a] = hi;
         b[6+a] = o;
         b[9+a] = d;
      end
      return b;
   endfunction

   initial begin
      ray_box_type b;
      add_box(make_box(-32'sh10000, 32'sh10000, 32'sh0, 32'sh10000));
      add_box(make_box(-32'sh10000, 32'sh10000, -32'sh50000, 32'sh10000));
      add_box(make_box(-32'sh10000, 32'sh10000, 32'sh50000, -32'sh10000));
      add_box(make_box(-32'sh10000, 32'sh10000, 32'sh0, 32'sh0));
      add_box(make_box(-32'sh10000, 32'sh10000, 32'sh20000, 32'sh0));
      add_box(make_box(COORD_MIN, COORD_MAX, 32'sh0, 32'sh0));
      add_box(make_box(COORD_MIN, COORD_MAX, COORD_MIN, 32'sh1));
      add_box(make_box(COORD_MIN, COORD_MAX, COORD_MAX, -32'sh1));
      add_box(make_box(COORD_MIN, COORD_MAX, 32'sh0, COORD_MIN));
      add_box(make_box(COORD_MIN, COORD_MAX, 32'sh0, COORD_MAX));
      add_box(make_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN));
      add_box(make_box(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX));
      add_box(make_box(32'sh10000, -32'sh10000, 32'sh0, 32'sh10000));
      add_box(make_box(32'sh10000, -32'sh10000, 32'sh0, 32'sh0));
      add_box(make_box(-32'sh1, -32'sh1, -32'sh1, -32'sh1));
      add_box(make_box(32'sh0, 32'sh0, 32'sh0, 32'sh0));
      b = make_box(-32'sh10000, 32'sh10000, 32'sh0, 32'sh10000);
      b[7] = 32'sh80000;
      b[10] = -32'sh1000;
      add_box(b);
      b[10] = 32'sh0;
      b[11] = 32'sh3;
      add_box(b);
      for (int i = 0; i < 400; i++) add_box(random_ray_box());
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (pending_boxes.size() == 0 && start == 1'b0);
      wait (expected_hits.size() == 0);
      repeat (TOTAL_LAT + 10) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   always @(negedge clock) begin
      ray_box_type b;
      bit          drive;
      if (!reset) begin
         if (beat_taken) begin
            void'(pending_boxes.pop_front());
            sent++;
         end
         drive = 1'b0;
         if (pending_boxes.size() != 0 &&
             !(sent == PAUSE_AT && expected_hits.size() != 0)) begin
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               drive = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         if (drive) begin
            b = pending_boxes[0];
            for (int i = 0; i < 12; i++) req_f[i] <= b[i];
         end
         start <= drive;
      end
   end

   always @(posedge clock) begin
      slab_result_type want;
      ray_box_type     b;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
      beat_taken = !reset && start && !busy;
      if (beat_taken) begin
         for (int i = 0; i < 12; i++) b[i] = req_f[i];
         expected_hits.insert(expected_hits.size(), predict_slab_hit(b));
      end
      if (!reset && rsp_valid) begin
         if (expected_hits.size() == 0) begin
            $error("unexpected result beat");
            errors++;
         end else begin
            want = expected_hits.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("hit expected %0d actual %0d", want.hit, rsp_hit);
               errors++;
            end
            if (rsp_t_near !== want.t_near) begin
               $error("t_near expected %0d actual %0d", want.t_near, rsp_t_near);
               errors++;
            end
            if (rsp_t_far !== want.t_far) begin
               $error("t_far expected %0d actual %0d", want.t_far, rsp_t_far);
               errors++;
            end
         end
      end
   end

endmodule
